>>> rtl/rvc_pkg.sv
// Shared constants for the radial vignette correction block.
`timescale 1ns / 1ps
`default_nettype none
package rvc_pkg;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 8;
    localparam int DIM_REG_W  = 13;
    localparam int K_W        = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_BITS     = 8;
    localparam int DEF_MAX_DIM = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_K   = 2'd2;

    localparam logic [DIM_REG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [DIM_REG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [K_W-1:0]       K_RESET      = 16'd0;
endpackage
`default_nettype wire

>>> rtl/rvc_divider.sv
// Pipelined restoring divider: 8-bit quotient, saturating at 255.
`timescale 1ns / 1ps
`default_nettype none
module rvc_divider #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 41
) (
    input  wire                         aclk,
    input  wire                         en,
    input  wire  [NUM_W-1:0]            num,
    input  wire  [DEN_W-1:0]            den,
    output logic [rvc_pkg::Q_BITS-1:0]  quot
);
    localparam int QB = rvc_pkg::Q_BITS;

    logic [NUM_W-1:0] rem_reg [QB+1];
    logic [DEN_W-1:0] den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    logic             ovf_reg [QB+1];

    // stage 0: quotient would not fit in 8 bits
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (num >= (NUM_W'(den) << QB));
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int SH = QB - 1 - j;
        logic [NUM_W-1:0] dsh;
        logic             take;
        assign dsh  = NUM_W'(den_reg[j]) << SH;
        assign take = rem_reg[j] >= dsh;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= take ? rem_reg[j] - dsh : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_reg[j] | (QB'(take) << SH);
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quot = ovf_reg[QB] ? '1 : q_reg[QB];
endmodule
`default_nettype wire

>>> rtl/radial_vignette_correction_unit.sv
// Top level of the radial vignette correction pipeline.
// Usage: pixels enter on the s_ channel (col, row, blue/green/red) with
// valid/ready and leave corrected on the m_ channel, one result beat per
// input beat, in order. Configuration (width, height, strength k) is written
// through cfg_we/cfg_idx/cfg_wdata while the pipeline is empty.
// Pipeline: 4 geometry/multiply stages, 9 divider stages and an output
// register lie between an accepted beat and m_valid.
// Throughput: one pixel per cycle unless stalled; the 8-bit quotient is
// produced one bit per pipeline stage by a restoring divider per channel.
// Stall: the whole pipeline advances only when the output register is free
// or being taken; s_ready falls while m_valid is high and m_ready is low,
// nothing is lost or repeated.
// Reset: aresetn (synchronous, active low) empties the pipeline and loads
// width 640, height 480, strength 0.
`timescale 1ns / 1ps
`default_nettype none
module radial_vignette_correction_unit #(
    parameter int MAX_DIM = rvc_pkg::DEF_MAX_DIM
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [rvc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire  [rvc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [rvc_pkg::COORD_W-1:0]      s_col,
    input  wire  [rvc_pkg::COORD_W-1:0]      s_row,
    input  wire  [rvc_pkg::PIX_W-1:0]        s_blue_in,
    input  wire  [rvc_pkg::PIX_W-1:0]        s_green_in,
    input  wire  [rvc_pkg::PIX_W-1:0]        s_red_in,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [rvc_pkg::PIX_W-1:0]        m_blue_out,
    output logic [rvc_pkg::PIX_W-1:0]        m_green_out,
    output logic [rvc_pkg::PIX_W-1:0]        m_red_out
);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW2   = rvc_pkg::COORD_W + 1;
    localparam int AW    = (DW > CW2) ? DW : CW2;
    localparam int SW    = 2 * DW + 1;
    localparam int RW    = 2 * AW + 1;
    localparam int KW    = rvc_pkg::K_W;
    localparam int PW    = rvc_pkg::PIX_W;
    localparam int DEN_W = SW + KW;
    localparam int NUM_W = DEN_W + PW;
    localparam int LAT   = 5 + rvc_pkg::Q_BITS + 1;

    logic [rvc_pkg::DIM_REG_W-1:0] width_reg, height_reg;
    logic [KW-1:0]                 k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rvc_pkg::WIDTH_RESET;
            height_reg <= rvc_pkg::HEIGHT_RESET;
            k_reg      <= rvc_pkg::K_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                rvc_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[rvc_pkg::DIM_REG_W-1:0];
                rvc_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[rvc_pkg::DIM_REG_W-1:0];
                rvc_pkg::REG_STRENGTH_K:   k_reg      <= cfg_wdata[KW-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] eff_dim(input logic [rvc_pkg::DIM_REG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)                  r = DW'(1);
        else if (32'(v) > MAX_DIM)    r = DW'(MAX_DIM);
        else                          r = DW'(v);
        return r;
    endfunction

    function automatic logic [AW-1:0] abs_diff(input logic [AW-1:0] a, input logic [AW-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    logic [DW-1:0] w_eff, h_eff;
    assign w_eff = eff_dim(width_reg);
    assign h_eff = eff_dim(height_reg);

    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[LAT-2:0], s_valid};
    end

    // stage 1: distances from the centre, doubled
    logic [AW-1:0] dx_reg, dy_reg;
    logic [DW-1:0] w1_reg, h1_reg;
    logic [PW-1:0] c1_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg    <= abs_diff(AW'({s_col, 1'b0}), AW'(w_eff));
            dy_reg    <= abs_diff(AW'({s_row, 1'b0}), AW'(h_eff));
            w1_reg    <= w_eff;
            h1_reg    <= h_eff;
            c1_reg[0] <= s_blue_in;
            c1_reg[1] <= s_green_in;
            c1_reg[2] <= s_red_in;
        end
    end

    // stage 2: squares
    logic [SW-1:0] s2_reg;
    logic [RW-1:0] r2_reg;
    logic [PW-1:0] c2_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_reg <= SW'(w1_reg * w1_reg) + SW'(h1_reg * h1_reg);
            r2_reg <= RW'(dx_reg * dx_reg) + RW'(dy_reg * dy_reg);
            c2_reg <= c1_reg;
        end
    end

    // stage 3: outside the image reads as the corner
    logic [SW-1:0] s3_reg, r3_reg;
    logic [PW-1:0] c3_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_reg <= s2_reg;
            r3_reg <= (r2_reg > RW'(s2_reg)) ? s2_reg : SW'(r2_reg);
            c3_reg <= c2_reg;
        end
    end

    // stage 4: divisor and per-channel dividends
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg [3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg <= (DEN_W'(s3_reg) << KW) - DEN_W'(k_reg * r3_reg);
            for (int i = 0; i < 3; i++)
                num_reg[i] <= NUM_W'(c3_reg[i] * s3_reg) << KW;
        end
    end

    logic [PW-1:0] q [3];
    for (genvar i = 0; i < 3; i++) begin : g_ch
        rvc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
            .aclk (aclk),
            .en   (adv),
            .num  (num_reg[i]),
            .den  (den_reg),
            .quot (q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_blue_out  <= q[0];
            m_green_out <= q[1];
            m_red_out   <= q[2];
        end
    end

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("pipeline not empty after reset");
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
endmodule
`default_nettype wire
